/* sv/wsdf_pkg.sv */
`default_nettype none

package wsdf_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    // opcodes that pass their payload on
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // 7-bit length codes that call for an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2047;

    // register address decode (index is paddr[2])
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] frame_opcode_out;
        logic       has_data;
        logic       frame_last;
        logic       too_large;
        logic       closed;
    } t_result;

    function automatic logic passes(input logic [3:0] op);
        return (op == OP_TEXT) || (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

`default_nettype wire

/* sv/websocket_frame_deframer_core.sv */
`default_nettype none

// channel   signals                               transfer when
// -------   -----------------------------------   -------------------------------
// in        i_in_valid, o_in_ready, i_in_byte     i_in_valid && o_in_ready
// out       o_out_valid, i_out_ready, o_*         o_out_valid && i_out_ready
// cfg       psel, penable, pwrite, paddr, ...     psel && penable && pwrite
//
// one received byte per cycle while o_in_ready is high; the parser state loads
// at the transfer edge; a result loads the output register, or skid if busy
// a two-entry output buffer (output register plus skid) keeps o_in_ready
// high while one result waits, so stalls cost nothing until both are full
// synchronous active-low reset: parser waits for a header byte, link open,
// fault clear, max_payload back to 2047; no clearing pass

module websocket_frame_deframer_core
    import wsdf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // received byte stream
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,

    // parsed results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_frame_opcode_out,
    output logic             o_has_data,
    output logic             o_frame_last,
    output logic             o_too_large,
    output logic             o_closed,

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_max_payload;
    logic        in_accept;
    logic        res_valid;
    t_result     res;
    t_result     out_res;
    logic        can_push;

    // register file: max_payload at byte offset 0
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD)) begin
            r_max_payload <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {16'd0, r_max_payload} : 32'd0;

    // byte transfer
    assign o_in_ready = can_push;
    assign in_accept  = i_in_valid && can_push;

    wsdf_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte        (i_in_byte),
        .i_max_payload (r_max_payload),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    wsdf_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_res      (res),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    // result fields
    assign o_data_byte        = out_res.data_byte;
    assign o_frame_opcode_out = out_res.frame_opcode_out;
    assign o_has_data         = out_res.has_data;
    assign o_frame_last       = out_res.frame_last;
    assign o_too_large        = out_res.too_large;
    assign o_closed           = out_res.closed;

endmodule

`default_nettype wire

/* sv/wsdf_parser.sv */
`default_nettype none

module wsdf_parser
    import wsdf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_max_payload,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cur_opcode, n_cur_opcode;
    logic        r_mask_present, n_mask_present;
    logic [63:0] r_length_left, n_length_left;
    logic [3:0]  r_length_bytes_left, n_length_bytes_left;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_mask_phase, n_mask_phase;
    logic        r_fault, n_fault;
    logic        r_link_open, n_link_open;

    logic        hd_done;
    logic [63:0] hd_len;
    logic [6:0]  l7;
    logic [63:0] ext_len;
    logic [7:0]  key_byte;
    logic        data_last;

    assign l7      = i_byte[6:0];
    assign ext_len = {r_length_left[55:0], i_byte};

    always_comb begin
        case (r_mask_phase)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    assign data_last = (r_length_left == 64'd1);

    always_comb begin
        n_phase             = r_phase;
        n_cur_opcode        = r_cur_opcode;
        n_mask_present      = r_mask_present;
        n_length_left       = r_length_left;
        n_length_bytes_left = r_length_bytes_left;
        n_mask_key          = r_mask_key;
        n_mask_phase        = r_mask_phase;
        n_fault             = r_fault;
        n_link_open         = r_link_open;
        hd_done             = 1'b0;
        hd_len              = 64'd0;
        o_res_valid         = 1'b0;
        o_res               = '0;
        o_res.frame_opcode_out = r_cur_opcode;

        if (i_accept && !r_fault && r_link_open) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_cur_opcode = i_byte[3:0];
                    n_phase      = PH_HDR1;
                end
                PH_HDR1: begin
                    n_mask_present = i_byte[7];
                    n_mask_key     = 32'd0;
                    n_length_left  = 64'd0;
                    if ((l7 == LEN_EXT16) || (l7 == LEN_EXT64)) begin
                        n_length_bytes_left = (l7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase             = PH_EXT;
                    end else begin
                        n_length_left = {57'd0, l7};
                        if (i_byte[7]) begin
                            n_length_bytes_left = MASK_BYTES;
                            n_phase             = PH_MASK;
                        end else begin
                            hd_done = 1'b1;
                            hd_len  = {57'd0, l7};
                        end
                    end
                end
                PH_EXT: begin
                    n_length_left       = ext_len;
                    n_length_bytes_left = r_length_bytes_left - 4'd1;
                    if (r_length_bytes_left == 4'd1) begin
                        if (r_mask_present) begin
                            n_length_bytes_left = MASK_BYTES;
                            n_phase             = PH_MASK;
                        end else begin
                            hd_done = 1'b1;
                            hd_len  = ext_len;
                        end
                    end
                end
                PH_MASK: begin
                    n_mask_key          = {r_mask_key[23:0], i_byte};
                    n_length_bytes_left = r_length_bytes_left - 4'd1;
                    if (r_length_bytes_left == 4'd1) begin
                        hd_done = 1'b1;
                        hd_len  = r_length_left;
                    end
                end
                PH_DATA: begin
                    n_mask_phase  = r_mask_phase + 2'd1;
                    n_length_left = r_length_left - 64'd1;
                    if (data_last) begin
                        n_phase = PH_HDR0;
                    end
                    if (passes(r_cur_opcode)) begin
                        o_res_valid      = 1'b1;
                        o_res.data_byte  = r_mask_present ? (i_byte ^ key_byte) : i_byte;
                        o_res.has_data   = 1'b1;
                        o_res.frame_last = data_last;
                        if (data_last && (r_cur_opcode == OP_CLOSE)) begin
                            n_link_open  = 1'b0;
                            o_res.closed = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // header complete: length check, empty frame or payload
            if (hd_done) begin
                n_mask_phase = 2'd0;
                if ((|hd_len[63:16]) || (hd_len[15:0] > i_max_payload)) begin
                    n_fault         = 1'b1;
                    n_phase         = PH_HDR0;
                    o_res_valid     = 1'b1;
                    o_res.too_large = 1'b1;
                end else if (hd_len == 64'd0) begin
                    n_phase = PH_HDR0;
                    if (passes(r_cur_opcode)) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_last = 1'b1;
                        if (r_cur_opcode == OP_CLOSE) begin
                            n_link_open  = 1'b0;
                            o_res.closed = 1'b1;
                        end
                    end
                end else begin
                    n_phase = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= PH_HDR0;
            r_cur_opcode        <= 4'd0;
            r_mask_present      <= 1'b0;
            r_length_left       <= 64'd0;
            r_length_bytes_left <= 4'd0;
            r_mask_key          <= 32'd0;
            r_mask_phase        <= 2'd0;
            r_fault             <= 1'b0;
            r_link_open         <= 1'b1;
        end else begin
            r_phase             <= n_phase;
            r_cur_opcode        <= n_cur_opcode;
            r_mask_present      <= n_mask_present;
            r_length_left       <= n_length_left;
            r_length_bytes_left <= n_length_bytes_left;
            r_mask_key          <= n_mask_key;
            r_mask_phase        <= n_mask_phase;
            r_fault             <= n_fault;
            r_link_open         <= n_link_open;
        end
    end

endmodule

`default_nettype wire

/* sv/wsdf_out_buf.sv */
`default_nettype none

module wsdf_out_buf
    import wsdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_can_push = !r_skid_v;
    assign o_valid    = r_out_v;
    assign o_res      = r_out;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out   = i_res;
                n_out_v = i_push;
            end
        end else if (i_push) begin
            n_skid   = i_res;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    // run shape
    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int PHASE_BYTES   = 155;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int TIMEOUT_NS    = 3_000_000;

    // register map: max_payload is register 0, byte address 0
    localparam logic [2:0]  ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
    // value written before the closing frame so the oversize case is fixed
    localparam logic [15:0] TAIL_MAX_PAYLOAD = 16'd100;

    // an opcode that is parsed but never forwarded
    localparam logic [3:0] OP_BINARY = 4'h2;

    localparam t_result NO_RESULT = '0;

    // how the random frames encode their length
    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_WIDE16,
        LEN_WIDE64
    } t_len_form;

    // receiver stall patterns
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_EVERY4,
        SINK_SPARSE
    } t_sink_mode;

    // one byte on the wire; typed rows carry their result by hand
    typedef struct packed {
        logic [7:0] in_byte;
        logic       typed;
        t_result    res;
    } t_stim_row;

    localparam int DIR_ROWS = 26;
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        // empty text frame straight after reset
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, OP_TEXT, 1'b0, 1'b1, 1'b0, 1'b0}},
        // unmasked ping carrying the byte extremes
        '{8'h89, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, OP_PING, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, '{8'hFF, OP_PING, 1'b1, 1'b1, 1'b0, 1'b0}},
        // masked pong, one payload byte
        '{8'h8A, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h3C, 1'b0, NO_RESULT},
        // empty frame of a dropped opcode: no result at all
        '{8'h82, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        // fin clear, reserved bits set, 64-bit length of one
        '{8'h71, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT}
    };

    // closing sequences, one picked per run since each of them halts the parser
    localparam int TAIL_ROWS = 37;
    localparam t_stim_row TAIL [TAIL_ROWS] = '{
        // masked close frame, then bytes that must be ignored
        '{8'h88, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, NO_RESULT},
        '{8'h78, 1'b0, NO_RESULT},
        '{8'hAB, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h89, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        // 16-bit length one above the limit, then ignored bytes
        '{8'h82, 1'b0, NO_RESULT},
        '{8'h7E, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h65, 1'b1, '{8'h00, OP_BINARY, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h89, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        // 64-bit length with the top bit set, masked, fault after the key
        '{8'h81, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h11, 1'b0, NO_RESULT},
        '{8'h22, 1'b0, NO_RESULT},
        '{8'h33, 1'b0, NO_RESULT},
        '{8'h44, 1'b1, '{8'h00, OP_TEXT, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}
    };
    localparam int TAIL_FIRST [3] = '{0, 12, 21};
    localparam int TAIL_COUNT [3] = '{12, 9, 16};

    // dut ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_data_byte;
    logic [3:0]  o_frame_opcode_out;
    logic        o_has_data;
    logic        o_frame_last;
    logic        o_too_large;
    logic        o_closed;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // bytes waiting to go on the wire, results the parser owes us
    t_stim_row wire_bytes[$];
    t_result   pending_results[$];
    int        bytes_queued = 0;
    int        error_count  = 0;
    bit        hold_req     = 1'b0;
    // sender holds a byte that has not been transferred yet
    bit        sender_busy  = 1'b0;

    // deframer shadow: configuration and parser state
    logic [15:0] cfg_max_payload = MAX_PAYLOAD_RESET;
    t_phase      pr_phase        = PH_HDR0;
    logic [3:0]  pr_opcode       = '0;
    logic        pr_masked       = 1'b0;
    logic [63:0] pr_len_left     = '0;
    logic [3:0]  pr_hdr_left     = '0;
    logic [31:0] pr_key          = '0;
    logic [1:0]  pr_key_idx      = '0;
    logic        pr_fault        = 1'b0;
    logic        pr_open         = 1'b1;

    websocket_frame_deframer_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_byte          (i_in_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_data_byte        (o_data_byte),
        .o_frame_opcode_out (o_frame_opcode_out),
        .o_has_data         (o_has_data),
        .o_frame_last       (o_frame_last),
        .o_too_large        (o_too_large),
        .o_closed           (o_closed),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

    task automatic log_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // opcodes whose frames reach the output
    function automatic bit forwards(input logic [3:0] op);
        return op == OP_TEXT || op == OP_CLOSE || op == OP_PING || op == OP_PONG;
    endfunction

    function automatic t_result make_result(input logic [7:0] d, input logic has,
                                            input logic last, input logic big);
        t_result r;
        r.data_byte        = d;
        r.frame_opcode_out = pr_opcode;
        r.has_data         = has;
        r.frame_last       = last;
        r.too_large        = big;
        r.closed           = !pr_open;
        return r;
    endfunction

    // header fully in: size check, then empty frame or payload
    task automatic header_complete(output bit got, output t_result res);
        got = 1'b0;
        res = NO_RESULT;
        pr_key_idx = '0;
        if (pr_len_left > 64'(cfg_max_payload)) begin
            pr_fault = 1'b1;
            pr_phase = PH_HDR0;
            got = 1'b1;
            res = make_result(8'h00, 1'b0, 1'b0, 1'b1);
        end else if (pr_len_left == 0) begin
            pr_phase = PH_HDR0;
            if (forwards(pr_opcode)) begin
                if (pr_opcode == OP_CLOSE) pr_open = 1'b0;
                got = 1'b1;
                res = make_result(8'h00, 1'b0, 1'b1, 1'b0);
            end
        end else begin
            pr_phase = PH_DATA;
        end
    endtask

    // advance the shadow parser by one accepted byte
    task automatic parse_byte(input logic [7:0] b, output bit got, output t_result res);
        logic [6:0] len7;
        logic [7:0] d;
        logic       last;
        got = 1'b0;
        res = NO_RESULT;
        if (pr_fault || !pr_open) return;
        case (pr_phase)
            PH_HDR0: begin
                pr_opcode = b[3:0];
                pr_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                len7        = b[6:0];
                pr_masked   = b[7];
                pr_key      = '0;
                pr_len_left = '0;
                if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                    pr_hdr_left = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    pr_phase    = PH_EXT;
                end else begin
                    pr_len_left = 64'(len7);
                    if (pr_masked) begin
                        pr_hdr_left = MASK_BYTES;
                        pr_phase    = PH_MASK;
                    end else begin
                        header_complete(got, res);
                    end
                end
            end
            PH_EXT: begin
                pr_len_left = {pr_len_left[55:0], b};
                pr_hdr_left--;
                if (pr_hdr_left == 0) begin
                    if (pr_masked) begin
                        pr_hdr_left = MASK_BYTES;
                        pr_phase    = PH_MASK;
                    end else begin
                        header_complete(got, res);
                    end
                end
            end
            PH_MASK: begin
                pr_key = {pr_key[23:0], b};
                pr_hdr_left--;
                if (pr_hdr_left == 0) header_complete(got, res);
            end
            PH_DATA: begin
                // key bytes are applied most significant first
                d = pr_masked ? (b ^ pr_key[8 * (3 - int'(pr_key_idx)) +: 8]) : b;
                pr_key_idx++;
                pr_len_left--;
                last = (pr_len_left == 0);
                if (last) pr_phase = PH_HDR0;
                if (forwards(pr_opcode)) begin
                    if (last && pr_opcode == OP_CLOSE) pr_open = 1'b0;
                    got = 1'b1;
                    res = make_result(d, 1'b1, last, 1'b0);
                end
            end
            default: pr_phase = PH_HDR0;
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b);
        wire_bytes.push_back('{b, 1'b0, NO_RESULT});
        bytes_queued++;
    endtask

    // one well-formed frame sized for the current limit; close is kept out
    task automatic queue_frame(input int mp);
        logic [3:0]  op;
        logic [3:0]  hdr_hi;
        logic        masked;
        logic [31:0] key;
        logic [63:0] len;
        t_len_form   form;
        int          cap;
        int          pick;
        int          i;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            pick = $urandom_range(0, 2);
            op = (pick == 0) ? OP_TEXT : (pick == 1) ? OP_PING : OP_PONG;
        end else begin
            do op = 4'($urandom_range(0, 15)); while (forwards(op));
        end
        cap = (mp < 24) ? mp : 24;
        len = 64'($urandom_range(0, cap));
        pick = $urandom_range(0, 11);
        if (pick == 0 && mp >= 126) len = 64'($urandom_range(126, (mp < 200) ? mp : 200));
        else if (pick == 1 && mp <= 200) len = 64'(mp);
        if (len >= 126) form = $urandom_range(0, 1) ? LEN_WIDE64 : LEN_WIDE16;
        else if ($urandom_range(0, 9) < 6) form = LEN_SHORT;
        else form = $urandom_range(0, 1) ? LEN_WIDE64 : LEN_WIDE16;
        hdr_hi = 4'($urandom_range(0, 15));
        masked = 1'($urandom_range(0, 1));
        key    = $urandom;
        queue_byte({hdr_hi, op});
        case (form)
            LEN_SHORT: queue_byte({masked, len[6:0]});
            LEN_WIDE16: begin
                queue_byte({masked, LEN_EXT16});
                queue_byte(len[15:8]);
                queue_byte(len[7:0]);
            end
            default: begin
                queue_byte({masked, LEN_EXT64});
                for (i = 7; i >= 0; i--) queue_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked) for (i = 3; i >= 0; i--) queue_byte(key[8 * i +: 8]);
        for (i = 0; i < int'(len); i++) queue_byte(8'($urandom_range(0, 255)));
    endtask

    // setup cycle, then access cycle held until pready
    task automatic apb_transfer(input bit is_write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_max_payload(input logic [15:0] mp);
        logic [31:0] rd;
        apb_transfer(1'b1, ADDR_MAX_PAYLOAD, 32'(mp), rd);
        cfg_max_payload = mp;
        apb_transfer(1'b0, ADDR_MAX_PAYLOAD, '0, rd);
        if (rd !== 32'(mp))
            log_error($sformatf("max_payload reads %08h, wrote %04h", rd, mp));
    endtask

    // nothing left to send, nothing owed, then let the pipe settle
    task automatic wait_idle();
        @(posedge i_clk);
        while (wire_bytes.size() != 0 || sender_busy || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input side: bursts of transfers with random gaps between them
    initial begin : byte_sender
        t_stim_row cur;
        bit        busy;
        bit        got;
        t_result   res;
        int        burst_left;
        int        gap_left;
        busy       = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        cur        = '0;
        forever begin
            @(posedge i_clk);
            // transfer at this edge: run the shadow parser on the byte
            if (busy && o_in_ready) begin
                parse_byte(cur.in_byte, got, res);
                if (cur.typed) pending_results.push_back(cur.res);
                else if (got) pending_results.push_back(res);
                busy = 1'b0;
            end
            if (!busy && i_rst_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (wire_bytes.size() != 0) begin
                    cur  = wire_bytes.pop_front();
                    busy = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            sender_busy = busy;
            // one assignment per edge so a held valid never glitches low
            i_in_valid <= busy;
            i_in_byte  <= cur.in_byte;
        end
    end

    task automatic check_result();
        t_result got;
        t_result want;
        string   diffs;
        got.data_byte        = o_data_byte;
        got.frame_opcode_out = o_frame_opcode_out;
        got.has_data         = o_has_data;
        got.frame_last       = o_frame_last;
        got.too_large        = o_too_large;
        got.closed           = o_closed;
        if (pending_results.size() == 0) begin
            log_error($sformatf("unexpected result data %02h op %h has %b last %b big %b cl %b",
                      got.data_byte, got.frame_opcode_out, got.has_data, got.frame_last,
                      got.too_large, got.closed));
            return;
        end
        want  = pending_results.pop_front();
        diffs = "";
        if (got.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
        if (got.frame_opcode_out !== want.frame_opcode_out) diffs = {diffs, " opcode"};
        if (got.has_data !== want.has_data) diffs = {diffs, " has_data"};
        if (got.frame_last !== want.frame_last) diffs = {diffs, " frame_last"};
        if (got.too_large !== want.too_large) diffs = {diffs, " too_large"};
        if (got.closed !== want.closed) diffs = {diffs, " closed"};
        if (diffs != "")
            log_error($sformatf("%s: got %02h/%h/%b%b%b%b want %02h/%h/%b%b%b%b", diffs,
                      got.data_byte, got.frame_opcode_out, got.has_data, got.frame_last,
                      got.too_large, got.closed, want.data_byte, want.frame_opcode_out,
                      want.has_data, want.frame_last, want.too_large, want.closed));
    endtask

    // output side: checks each transfer, stalls on its own pattern
    initial begin : result_sink
        t_sink_mode mode;
        int         seg_left;
        int         hold_left;
        int         tick;
        bit         rdy;
        mode      = SINK_OPEN;
        seg_left  = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            // long hold-off so the buffer fills and the input stalls
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_sink_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 120);
                end
                seg_left--;
                tick++;
                case (mode)
                    SINK_OPEN:   rdy = 1'b1;
                    SINK_COIN:   rdy = 1'($urandom_range(0, 1));
                    SINK_EVERY4: rdy = (tick % 4 == 0);
                    default:     rdy = ($urandom_range(0, 7) == 0);
                endcase
            end
            i_out_ready <= rdy;
        end
    end

    // main sequence: reset, directed table, random phases per limit, one halting case
    initial begin : run_sequence
        logic [31:0] rd;
        int          p;
        int          mp;
        int          target;
        int          pick;
        int          i;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register comes out of reset at its default
        apb_transfer(1'b0, ADDR_MAX_PAYLOAD, '0, rd);
        if (rd !== 32'(MAX_PAYLOAD_RESET))
            log_error($sformatf("max_payload after reset reads %08h", rd));

        for (i = 0; i < DIR_ROWS; i++) wire_bytes.push_back(DIRECTED[i]);
        wait_idle();

        // limit settings: zero, full scale, small, random, default
        for (p = 0; p < 5; p++) begin
            case (p)
                0:       mp = 0;
                1:       mp = 65535;
                2:       mp = $urandom_range(8, 60);
                3:       mp = $urandom_range(0, 65535);
                default: mp = MAX_PAYLOAD_RESET;
            endcase
            set_max_payload(16'(mp));
            if (p == 1) hold_req = 1'b1;
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) queue_frame(mp);
            wait_idle();
        end

        // one halting case per run: close, oversize 16-bit, or 64-bit top bit
        set_max_payload(TAIL_MAX_PAYLOAD);
        pick = $urandom_range(0, 2);
        for (i = 0; i < TAIL_COUNT[pick]; i++) wire_bytes.push_back(TAIL[TAIL_FIRST[pick] + i]);
        wait_idle();

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* websocket_frame_deframer_core.f */
sv/wsdf_pkg.sv
sv/wsdf_parser.sv
sv/wsdf_out_buf.sv
sv/websocket_frame_deframer_core.sv
tb/tb_top.sv
